[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checked outside reset
`define MLDV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define MLDV_ASSERT_IMP(lbl, ante, cons, msg) \
  `MLDV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/mldv_pkg.sv]
// shared constants, tables and codes of the mouse look direction block
package mldv_pkg;

  localparam logic [24:0] DEG90   = 25'd5898240;
  localparam logic [24:0] DEG180  = 25'd11796480;
  localparam logic [24:0] DEG270  = 25'd17694720;
  localparam logic [24:0] DEG360  = 25'd23592960;
  localparam logic [31:0] RAD_Q30 = 32'd18740330;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic [19:0] SENS_RST = 20'd6554;
  localparam logic [22:0] PLIM_RST = 23'd5832704;
  localparam logic [24:0] YAW_RST  = 25'd17694720;

  // horner term k divides by (2k)(2k+1); done as a reciprocal multiply
  // q0 = (v * recip) >> shift, which is exact or one below
  localparam int unsigned HORNER_SHIFT [8] = '{0, 34, 36, 37, 38, 38, 39, 39};
  localparam logic [7:0]  HORNER_DIV   [8] = '{8'd1, 8'd6, 8'd20, 8'd42, 8'd72,
                                                8'd110, 8'd156, 8'd210};
  localparam logic [31:0] HORNER_RECIP [8] = '{
    32'd0,
    32'((64'd1 << 34) / 64'd6),
    32'((64'd1 << 36) / 64'd20),
    32'((64'd1 << 37) / 64'd42),
    32'((64'd1 << 38) / 64'd72),
    32'((64'd1 << 38) / 64'd110),
    32'((64'd1 << 39) / 64'd156),
    32'((64'd1 << 39) / 64'd210)
  };

  typedef enum logic [0:0] {
    REG_SENS = 1'b0,
    REG_PLIM = 1'b1
  } reg_idx_e;

endpackage

[rtl/mldv_mul.sv]
// shared 32x32 unsigned multiplier with registered product
module mldv_mul import mldv_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

[rtl/mldv_wrap.sv]
// reduction of a signed angle sum into 0 .. 360 degrees through the registers mag_q, fold_q and res_q
module mldv_wrap import mldv_pkg::*; #(
  parameter int unsigned SW = 38
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [SW-1:0] val_i,
  output logic                 done_o,
  output logic [24:0]          res_o
);

  // 360 degrees is 45 * 2^19: the low 19 bits pass through and the part
  // above them is reduced mod 45 by adding 12-bit chunks (2^12 is 1 mod 45)
  localparam int unsigned HW  = SW - 19;
  localparam int unsigned NCH = (HW + 11) / 12;
  // floor(s / 45) = (s * 5826) >> 18 for s below 10000
  localparam logic [12:0] RECIP45 = 13'd5826;
  localparam logic [12:0] DIV45   = 13'd45;

  logic [SW-1:0]     mag_q;
  logic              neg_q;
  logic [15:0]       fold_q;
  logic              s1_q, s2_q, done_q;
  logic [24:0]       res_q;
  logic [NCH*12-1:0] hi;
  logic [15:0]       fold;
  logic [12:0]       fsum;
  logic [24:0]       qp;
  logic [6:0]        quo;
  logic [5:0]        r45;
  logic [24:0]       rem_lo;

  always_comb begin
    hi   = (NCH*12)'(mag_q[SW-1:19]);
    fold = '0;
    for (int i = 0; i < NCH; i++) begin
      fold = fold + 16'(hi[i*12 +: 12]);
    end
  end

  assign fsum   = 13'(fold_q[11:0]) + 13'(fold_q[15:12]);
  assign qp     = 25'(fsum) * 25'(RECIP45);
  assign quo    = qp[24:18];
  assign r45    = 6'(fsum - 13'(quo) * DIV45);
  assign rem_lo = {r45, mag_q[18:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= val_i[SW-1] ? SW'(-val_i) : SW'(val_i);
      neg_q <= val_i[SW-1];
    end
    if (s1_q) fold_q <= fold;
    if (s2_q) res_q <= (neg_q && rem_lo != '0) ? DEG360 - rem_lo : rem_lo;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

[rtl/mldv_trig.sv]
// sequencer for four sines by taylor series and the three direction products
module mldv_trig import mldv_pkg::*; #(
  parameter int unsigned FRAC = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [24:0]          yaw_i,
  input  logic [24:0]          pa_i,
  output logic                 done_o,
  output logic signed [FRAC:0] dir_x_o,
  output logic signed [FRAC:0] dir_y_o,
  output logic signed [FRAC:0] dir_z_o
);

  localparam int unsigned SH   = 60 - FRAC;
  localparam logic [63:0] HALF = 64'd1 << (SH - 1);
  localparam logic [63:0] LIM  = 64'd1 << FRAC;

  typedef enum logic [13:0] {
    T_IDLE = 14'b00000000000001,
    T_ANG  = 14'b00000000000010,
    T_QUAD = 14'b00000000000100,
    T_MX   = 14'b00000000001000,
    T_XQ   = 14'b00000000010000,
    T_MSQ  = 14'b00000000100000,
    T_X2Q  = 14'b00000001000000,
    T_MT   = 14'b00000010000000,
    T_MR   = 14'b00000100000000,
    T_TQ   = 14'b00001000000000,
    T_MS   = 14'b00010000000000,
    T_SQ   = 14'b00100000000000,
    T_MO   = 14'b01000000000000,
    T_RO   = 14'b10000000000000
  } tstate_e;

  tstate_e     st_q, st_d;
  logic [1:0]  ai_q, oj_q;
  logic [2:0]  k_q;
  logic        done_q;
  logic [24:0] yaw_q, pa_q, a_q;
  logic [22:0] r_q;
  logic        neg_q;
  logic [31:0] x_q, x2_q, t_q, v_q;
  logic [31:0] sy_q, cy_q, sp_q, cp_q;
  logic        sy_n_q, cy_n_q, sp_n_q, cp_n_q;
  logic signed [FRAC:0] dx_q, dy_q, dz_q;

  logic        mul_en;
  logic [31:0] op_a, op_b;
  logic [63:0] p;

  logic [25:0] ang_sum;
  logic [24:0] ang_red;
  logic [1:0]  quad;
  logic [24:0] q_lo, q_hi;
  logic [31:0] q0, qf;
  logic [39:0] qd, rem;
  logic [31:0] mag;
  logic        oneg;
  logic [63:0] rnd, sat;
  logic [FRAC:0] res;

  mldv_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (p)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    op_a   = '0;
    op_b   = '0;
    unique case (st_q)
      T_MX: begin
        op_a = 32'(r_q);
        op_b = RAD_Q30;
      end
      T_MSQ: begin
        op_a = x_q;
        op_b = x_q;
      end
      T_MT: begin
        op_a = x2_q;
        op_b = t_q;
      end
      T_MR: begin
        op_a = p[61:30];
        op_b = HORNER_RECIP[k_q];
      end
      T_MS: begin
        op_a = x_q;
        op_b = t_q;
      end
      T_MO: begin
        unique case (oj_q)
          2'd0:    begin op_a = cy_q; op_b = cp_q;    end
          2'd1:    begin op_a = sp_q; op_b = ONE_Q30; end
          default: begin op_a = sy_q; op_b = cp_q;    end
        endcase
      end
      default: mul_en = 1'b0;
    endcase
  end

  // angle reduction and quadrant split
  always_comb begin
    ang_sum = 26'(ai_q[1] ? pa_q : yaw_q) + (ai_q[0] ? 26'(DEG90) : 26'd0);
    ang_red = (ang_sum >= 26'(DEG360)) ? 25'(ang_sum - 26'(DEG360)) : ang_sum[24:0];
    if (a_q >= DEG270) begin
      quad = 2'd3; q_lo = DEG270; q_hi = DEG360;
    end else if (a_q >= DEG180) begin
      quad = 2'd2; q_lo = DEG180; q_hi = DEG270;
    end else if (a_q >= DEG90) begin
      quad = 2'd1; q_lo = DEG90;  q_hi = DEG180;
    end else begin
      quad = 2'd0; q_lo = '0;     q_hi = DEG90;
    end
  end

  // horner division by (2k)(2k+1) with one correction step
  always_comb begin
    q0  = 32'(p >> HORNER_SHIFT[k_q]);
    qd  = 40'(q0) * 40'(HORNER_DIV[k_q]);
    rem = 40'(v_q) - qd;
    qf  = (rem >= 40'(HORNER_DIV[k_q])) ? q0 + 32'd1 : q0;
  end

  // round half away from zero and saturate
  always_comb begin
    mag = p[61:30];
    unique case (oj_q)
      2'd0:    oneg = cy_n_q ^ cp_n_q;
      2'd1:    oneg = sp_n_q;
      default: oneg = sy_n_q ^ cp_n_q;
    endcase
    rnd = (p + HALF) >> SH;
    if (!oneg && rnd > LIM - 64'd1) begin
      sat = LIM - 64'd1;
    end else if (oneg && rnd > LIM) begin
      sat = LIM;
    end else begin
      sat = rnd;
    end
    res = (FRAC+1)'(oneg ? 64'd0 - sat : sat);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      T_IDLE:  if (start_i) st_d = T_ANG;
      T_ANG:   st_d = T_QUAD;
      T_QUAD:  st_d = T_MX;
      T_MX:    st_d = T_XQ;
      T_XQ:    st_d = T_MSQ;
      T_MSQ:   st_d = T_X2Q;
      T_X2Q:   st_d = T_MT;
      T_MT:    st_d = T_MR;
      T_MR:    st_d = T_TQ;
      T_TQ:    st_d = (k_q == 3'd1) ? T_MS : T_MT;
      T_MS:    st_d = T_SQ;
      T_SQ:    st_d = (ai_q == 2'd3) ? T_MO : T_ANG;
      T_MO:    st_d = T_RO;
      T_RO:    st_d = (oj_q == 2'd2) ? T_IDLE : T_MO;
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= T_IDLE;
      ai_q   <= '0;
      oj_q   <= '0;
      k_q    <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == T_RO) && (oj_q == 2'd2);
      if (st_q == T_IDLE) begin
        ai_q <= '0;
        oj_q <= '0;
      end
      if (st_q == T_SQ) ai_q <= ai_q + 2'd1;
      if (st_q == T_RO) oj_q <= oj_q + 2'd1;
      if (st_q == T_X2Q) k_q <= 3'd7;
      if (st_q == T_TQ) k_q <= k_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      T_IDLE: begin
        if (start_i) begin
          yaw_q <= yaw_i;
          pa_q  <= pa_i;
        end
      end
      T_ANG:  a_q <= ang_red;
      T_QUAD: begin
        r_q   <= 23'(quad[0] ? q_hi - a_q : a_q - q_lo);
        neg_q <= quad[1];
      end
      T_XQ:  x_q <= 32'((p + 64'd32768) >> 16);
      T_X2Q: begin
        x2_q <= p[61:30];
        t_q  <= ONE_Q30;
      end
      T_MR: v_q <= p[61:30];
      T_TQ: t_q <= ONE_Q30 - qf;
      T_SQ: begin
        unique case (ai_q)
          2'd0:    begin sy_q <= mag; sy_n_q <= neg_q; end
          2'd1:    begin cy_q <= mag; cy_n_q <= neg_q; end
          2'd2:    begin sp_q <= mag; sp_n_q <= neg_q; end
          default: begin cp_q <= mag; cp_n_q <= neg_q; end
        endcase
      end
      T_RO: begin
        unique case (oj_q)
          2'd0:    dx_q <= res;
          2'd1:    dy_q <= res;
          default: dz_q <= res;
        endcase
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign dir_x_o = dx_q;
  assign dir_y_o = dy_q;
  assign dir_z_o = dz_q;

endmodule

[rtl/mouse_look_direction_vector_core.sv]
// top level: cursor items in, yaw/pitch update, direction vector items out
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       cursor_x, cursor_y
//  m_axis    out  m_axis_tvalid/tready       dir_x, dir_y, dir_z, yaw_angle, pitch_angle
//  apb       in   psel/penable/pwrite/pready sensitivity @0x0, pitch_limit @0x4
//
// one item runs, with the output free, through: accept, the product states
// MULX and MULY, the pitch clamp, the 360 degree wrap, a trig start state, the
// trig sequencer (each sine, then each output product), its done state and
// the output load. input ready only while idle; a held output item keeps the
// core in its done state. reset is asynchronous, no clearing pass.
`include "assert_macros.svh"

module mouse_look_direction_vector_core import mldv_pkg::*; #(
  parameter int unsigned COORD_WIDTH             = 16,
  parameter int unsigned DIRECTION_FRACTION_BITS = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  // cursor_x, cursor_y (low to high), zero padded
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // dir_x, dir_y, dir_z, yaw_angle, pitch_angle (low to high), zero padded
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((3*(DIRECTION_FRACTION_BITS+1)+49+7)/8)*8-1:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned F     = DIRECTION_FRACTION_BITS;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned PW    = CW + 21;
  localparam int unsigned SW    = CW + 22;
  localparam int unsigned OUT_W = ((3*(F+1)+49+7)/8)*8;
  localparam logic signed [23:0] PITCH_MAX = 24'sd5898240;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_MULX = 8'b00000010,
    ST_MULY = 8'b00000100,
    ST_SAT  = 8'b00001000,
    ST_WRAP = 8'b00010000,
    ST_TGO  = 8'b00100000,
    ST_TRIG = 8'b01000000,
    ST_DONE = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [19:0] sens_q;
  logic [22:0] plim_q;
  logic        first_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q;
  logic [24:0]          yaw_q;
  logic signed [23:0]   pitch_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] ysum_q;

  logic signed [CW-1:0] cx, cy;
  logic                 in_acc;
  logic                 apb_wr;
  reg_idx_e             widx;
  logic signed [DW-1:0] mul_sel;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] psum, lim_s;
  logic [22:0]          lim;
  logic signed [23:0]   pitch_d;
  logic [24:0]          pa;

  logic        wrap_done;
  logic [24:0] wrap_res;
  logic        trig_done;
  logic signed [F:0] tdx, tdy, tdz;

  logic              ovalid_q;
  logic signed [F:0] odx_q, ody_q, odz_q;
  logic [24:0]       oyaw_q;
  logic signed [23:0] opitch_q;
  logic              load;

  assign cx     = s_axis_tdata[CW-1:0];
  assign cy     = s_axis_tdata[2*CW-1:CW];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;
  assign widx   = reg_idx_e'(paddr[2]);
  always_comb begin
    unique case (widx)
      REG_SENS: prdata = 32'(sens_q);
      default:  prdata = 32'(plim_q);
    endcase
  end

  // angle update
  assign mul_sel = (state_q == ST_MULY) ? dy_q : dx_q;
  assign prod    = PW'(mul_sel) * PW'($signed({1'b0, sens_q}));
  assign psum    = SW'(pitch_q) + SW'(prod_q);
  assign lim     = (25'(plim_q) > DEG90) ? 23'(DEG90) : plim_q;
  assign lim_s   = SW'($signed({1'b0, lim}));

  always_comb begin
    if (psum > lim_s) begin
      pitch_d = 24'(lim_s);
    end else if (psum < -lim_s) begin
      pitch_d = 24'(-lim_s);
    end else begin
      pitch_d = 24'(psum);
    end
  end

  assign pa   = pitch_q[23] ? DEG360 + 25'(pitch_q) : 25'(pitch_q);
  assign load = (state_q == ST_DONE) && (!ovalid_q || m_axis_tready);

  mldv_wrap #(.SW(SW)) u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SAT),
    .val_i   (ysum_q),
    .done_o  (wrap_done),
    .res_o   (wrap_res)
  );

  mldv_trig #(.FRAC(F)) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_TGO),
    .yaw_i   (yaw_q),
    .pa_i    (pa),
    .done_o  (trig_done),
    .dir_x_o (tdx),
    .dir_y_o (tdy),
    .dir_z_o (tdz)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MULX;
      ST_MULX: state_d = ST_MULY;
      ST_MULY: state_d = ST_SAT;
      ST_SAT:  state_d = ST_WRAP;
      ST_WRAP: if (wrap_done) state_d = ST_TGO;
      ST_TGO:  state_d = ST_TRIG;
      ST_TRIG: if (trig_done) state_d = ST_DONE;
      ST_DONE: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sens_q   <= SENS_RST;
      plim_q   <= PLIM_RST;
      first_q  <= 1'b1;
      prev_x_q <= CW'(400);
      prev_y_q <= CW'(300);
      yaw_q    <= YAW_RST;
      pitch_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apb_wr) begin
        unique case (widx)
          REG_SENS: sens_q <= pwdata[19:0];
          default:  plim_q <= pwdata[22:0];
        endcase
      end
      if (in_acc) begin
        first_q  <= 1'b0;
        prev_x_q <= cx;
        prev_y_q <= cy;
      end
      if (state_q == ST_SAT) pitch_q <= pitch_d;
      if (wrap_done) yaw_q <= wrap_res;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      // first item after reset latches the position, so no movement
      dx_q <= first_q ? '0 : DW'(cx) - DW'(prev_x_q);
      dy_q <= first_q ? '0 : DW'(prev_y_q) - DW'(cy);
    end
    if (state_q == ST_MULX || state_q == ST_MULY) prod_q <= prod;
    if (state_q == ST_MULY) ysum_q <= SW'($signed({1'b0, yaw_q})) + SW'(prod_q);
    if (load) begin
      odx_q    <= tdx;
      ody_q    <= tdy;
      odz_q    <= tdz;
      oyaw_q   <= yaw_q;
      opitch_q <= pitch_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_W'({opitch_q, oyaw_q, odz_q, ody_q, odx_q});

  `MLDV_ASSERT_IMP(a_wrap_in_state, wrap_done, state_q == ST_WRAP, "wrap done outside wrap")
  `MLDV_ASSERT_IMP(a_trig_in_state, trig_done, state_q == ST_TRIG, "trig done outside trig")
  `MLDV_ASSERT(a_accept_starts, in_acc |=> state_q == ST_MULX, "item did not start work")
  `MLDV_ASSERT_IMP(a_yaw_range, ovalid_q, oyaw_q < DEG360, "yaw out of range")
  `MLDV_ASSERT_IMP(a_pitch_range, ovalid_q, opitch_q <= PITCH_MAX && opitch_q >= -PITCH_MAX, "pitch out of range")

endmodule
